### rtl/core/rv32i_decode_execute_unit_macros.svh
// Assertion macros used by the decode and execute unit top level.
`ifndef RV32I_DECODE_EXECUTE_UNIT_MACROS_SVH
`define RV32I_DECODE_EXECUTE_UNIT_MACROS_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define RVDE_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Whenever the condition holds, the consequence holds in the next cycle.
`define RVDE_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

### rtl/core/rvde_pkg.sv
// Types and constants shared by the decode and execute unit.
`timescale 1ns / 1ps

package rvde_pkg;

	// Major opcodes of the base integer instruction set.
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;

	// ALU funct3 codes.
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// Branch funct3 codes.
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// Memory request kinds.
	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_LOAD  = 2'd1;
	localparam logic [1:0] MEM_STORE = 2'd2;

	localparam logic [31:0] LINK_STEP = 32'd4;
	localparam logic [31:0] JALR_MASK = 32'hFFFF_FFFE;

	typedef enum logic [3:0] {
		CLS_LUI,
		CLS_AUIPC,
		CLS_JAL,
		CLS_JALR,
		CLS_BRANCH,
		CLS_LOAD,
		CLS_STORE,
		CLS_OPIMM,
		CLS_OP,
		CLS_ILLEGAL
	} cls_t;

	// One input word.
	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] inst_address;
		logic [31:0] src1_value;
		logic [31:0] src2_value;
	} in_t;

	// One result word.
	typedef struct packed {
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic        dest_write;
		logic        jump_taken;
		logic [31:0] jump_target;
		logic [1:0]  mem_kind;
		logic [31:0] mem_address;
		logic [31:0] store_data;
		logic [1:0]  access_size;
		logic        load_unsigned;
		logic        illegal;
	} out_t;

	// Decoded fields of one instruction.
	typedef struct packed {
		cls_t        cls;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic        alt;
		logic [31:0] imm_i;
		logic [31:0] imm_s;
		logic [31:0] imm_b;
		logic [31:0] imm_j;
		logic [31:0] imm_u;
	} dec_t;

	// ALU and branch compare outcome.
	typedef struct packed {
		logic [31:0] value;
		logic        take;
		logic        br_bad;
	} alu_res_t;

endpackage

### rtl/core/rv32i_decode_execute_unit.sv
// Top level of the RV32I decode and execute unit.
`timescale 1ns / 1ps
`include "rv32i_decode_execute_unit_macros.svh"

// Decode and execute for one RV32I instruction word per cycle. A word is
// taken when start is high; busy is always low, so a new word may be given
// in every cycle. The word is captured in an input register, decoded and
// executed by one pass of combinational logic, and the result is captured
// in a result register: done pulses for one cycle once the word has passed
// both registers, with the result on the result port in that cycle. Throughput
// is one word per cycle, set by the single decode and ALU pass between the two
// registers. The receiver cannot stall the unit and must take each result in
// the cycle it appears.
module rv32i_decode_execute_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rvde_pkg::in_t   item,
	output logic            done,
	output rvde_pkg::out_t  result
);
	import rvde_pkg::*;

	logic           valid_s1;
	in_t            item_s1;
	logic           valid_s2;
	out_t           result_s2;
	dec_t           dec;
	alu_res_t       alu_r;
	out_t           res_c;
	logic           accept;

	// The unit never holds off a word.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	rvde_decode u_decode (
		.instruction (item_s1.instruction),
		.dec         (dec)
	);

	rvde_alu u_alu (
		.dec   (dec),
		.src1  (item_s1.src1_value),
		.src2  (item_s1.src2_value),
		.alu_o (alu_r)
	);

	// Result assembly; fields that do not apply stay zero.
	always_comb begin
		res_c = '0;
		unique case (dec.cls)
			CLS_LUI: begin
				res_c.dest_index = dec.rd;
				res_c.dest_value = dec.imm_u;
				res_c.dest_write = 1'b1;
			end
			CLS_AUIPC: begin
				res_c.dest_index = dec.rd;
				res_c.dest_value = dec.imm_u + item_s1.inst_address;
				res_c.dest_write = 1'b1;
			end
			CLS_JAL: begin
				res_c.dest_index  = dec.rd;
				res_c.dest_value  = item_s1.inst_address + LINK_STEP;
				res_c.dest_write  = 1'b1;
				res_c.jump_taken  = 1'b1;
				res_c.jump_target = item_s1.inst_address + dec.imm_j;
			end
			CLS_JALR: begin
				res_c.dest_index  = dec.rd;
				res_c.dest_value  = item_s1.inst_address + LINK_STEP;
				res_c.dest_write  = 1'b1;
				res_c.jump_taken  = 1'b1;
				res_c.jump_target = (item_s1.src1_value + dec.imm_i) & JALR_MASK;
			end
			CLS_BRANCH: begin
				if (alu_r.br_bad) begin
					res_c.illegal = 1'b1;
				end else begin
					res_c.jump_taken  = alu_r.take;
					res_c.jump_target = item_s1.inst_address + dec.imm_b;
				end
			end
			CLS_LOAD: begin
				res_c.dest_index    = dec.rd;
				res_c.mem_kind      = MEM_LOAD;
				res_c.mem_address   = item_s1.src1_value + dec.imm_i;
				res_c.access_size   = dec.f3[1:0];
				res_c.load_unsigned = dec.f3[2];
			end
			CLS_STORE: begin
				res_c.mem_kind    = MEM_STORE;
				res_c.mem_address = item_s1.src1_value + dec.imm_s;
				res_c.store_data  = item_s1.src2_value;
				res_c.access_size = dec.f3[1:0];
			end
			CLS_OPIMM, CLS_OP: begin
				res_c.dest_index = dec.rd;
				res_c.dest_value = alu_r.value;
				res_c.dest_write = 1'b1;
			end
			default: begin
				res_c.illegal = 1'b1;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= res_c;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;

	`RVDE_ASSERT_NEXT(a_word_gives_result, clk, arst_n, valid_s1, done, "word in execute gave no result")
	`RVDE_ASSERT_NEXT(a_no_spurious_result, clk, arst_n, !valid_s1, !done, "result without a word")
	`RVDE_ASSERT_SAME(a_illegal_is_noop, clk, arst_n, done && result.illegal, !result.dest_write && !result.jump_taken && result.mem_kind == MEM_NONE, "illegal word was not a no-op")
	`RVDE_ASSERT_SAME(a_write_no_mem, clk, arst_n, done && result.dest_write, result.mem_kind == MEM_NONE, "register write with memory request")
	`RVDE_ASSERT_SAME(a_mem_kind_valid, clk, arst_n, done, result.mem_kind <= MEM_STORE, "undefined memory kind")

endmodule

### rtl/core/rvde_decode.sv
// Instruction decoder: opcode class, register index, funct3 and immediates.
`timescale 1ns / 1ps

module rvde_decode (
	input  logic [31:0]   instruction,
	output rvde_pkg::dec_t dec
);
	import rvde_pkg::*;

	// Immediate forms and plain fields.
	always_comb begin
		dec.rd    = instruction[11:7];
		dec.f3    = instruction[14:12];
		dec.alt   = instruction[30];
		dec.imm_i = {{20{instruction[31]}}, instruction[31:20]};
		dec.imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
		dec.imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
			instruction[30:25], instruction[11:8], 1'b0};
		dec.imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
			instruction[20], instruction[30:21], 1'b0};
		dec.imm_u = {instruction[31:12], 12'b0};
	end

	// Opcode class.
	always_comb begin
		unique case (instruction[6:0])
			OPC_LUI:    dec.cls = CLS_LUI;
			OPC_AUIPC:  dec.cls = CLS_AUIPC;
			OPC_JAL:    dec.cls = CLS_JAL;
			OPC_JALR:   dec.cls = CLS_JALR;
			OPC_BRANCH: dec.cls = CLS_BRANCH;
			OPC_LOAD:   dec.cls = CLS_LOAD;
			OPC_STORE:  dec.cls = CLS_STORE;
			OPC_OPIMM:  dec.cls = CLS_OPIMM;
			OPC_OP:     dec.cls = CLS_OP;
			default:    dec.cls = CLS_ILLEGAL;
		endcase
	end

endmodule

### rtl/core/rvde_alu.sv
// Integer ALU and branch comparator.
`timescale 1ns / 1ps

module rvde_alu (
	input  rvde_pkg::dec_t     dec,
	input  logic [31:0]        src1,
	input  logic [31:0]        src2,
	output rvde_pkg::alu_res_t alu_o
);
	import rvde_pkg::*;

	logic [31:0] opb;
	logic [4:0]  shamt;
	logic        is_op;
	logic        lt_s;
	logic        lt_u;

	// Register-register forms take rs2; immediate forms take the I immediate.
	assign is_op = (dec.cls == CLS_OP);
	assign opb   = is_op ? src2 : dec.imm_i;
	assign shamt = opb[4:0];

	// Arithmetic and logic result; bit 30 picks sub only for register forms.
	always_comb begin
		unique case (dec.f3)
			F3_ADD:  alu_o.value = (is_op && dec.alt) ? src1 - opb : src1 + opb;
			F3_SLL:  alu_o.value = src1 << shamt;
			F3_SLT:  alu_o.value = {31'b0, $signed(src1) < $signed(opb)};
			F3_SLTU: alu_o.value = {31'b0, src1 < opb};
			F3_XOR:  alu_o.value = src1 ^ opb;
			F3_SR:   alu_o.value = dec.alt ? 32'($signed(src1) >>> shamt) : src1 >> shamt;
			F3_OR:   alu_o.value = src1 | opb;
			F3_AND:  alu_o.value = src1 & opb;
			default: alu_o.value = src1 & opb;
		endcase
	end

	// Branch condition always compares rs1 with rs2.
	assign lt_s = $signed(src1) < $signed(src2);
	assign lt_u = src1 < src2;

	always_comb begin
		alu_o.br_bad = 1'b0;
		unique case (dec.f3)
			F3_BEQ:  alu_o.take = (src1 == src2);
			F3_BNE:  alu_o.take = (src1 != src2);
			F3_BLT:  alu_o.take = lt_s;
			F3_BGE:  alu_o.take = !lt_s;
			F3_BLTU: alu_o.take = lt_u;
			F3_BGEU: alu_o.take = !lt_u;
			default: begin
				alu_o.take   = 1'b0;
				alu_o.br_bad = 1'b1;
			end
		endcase
	end

endmodule
